FILE: rtl/kcl_pkg.sv
package kcl_pkg;

   localparam logic [7:0] KEY_ONE = 8'h31;
   localparam logic [7:0] KEY_TWO = 8'h32;
   localparam logic [7:0] KEY_NONE = 8'h00;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   localparam logic [15:0] OPEN_POSITION_RESET = 16'd600;
   localparam logic [15:0] LOCK_POSITION_RESET = 16'd130;
   localparam logic [3:0] RETRY_RELOAD_RESET = 4'd2;
   localparam logic [7:0] CLEAR_KEY_RESET = 8'd99;

   localparam logic [1:0] CSR_OPEN_POSITION = 2'd0;
   localparam logic [1:0] CSR_LOCK_POSITION = 2'd1;
   localparam logic [1:0] CSR_RETRY_RELOAD = 2'd2;
   localparam logic [1:0] CSR_CLEAR_KEY = 2'd3;

   typedef enum logic [2:0] {
      EV_DIGIT   = 3'd0,
      EV_CLEARED = 3'd1,
      EV_SAVED   = 3'd2,
      EV_OPENING = 3'd3,
      EV_WRONG   = 3'd4,
      EV_BLOCKED = 3'd5,
      EV_LOCKING = 3'd6,
      EV_CHANGED = 3'd7
   } event_type;

   typedef struct packed {
      logic [15:0] open_position;
      logic [15:0] lock_position;
      logic [3:0]  retry_reload;
      logic [7:0]  clear_key;
   } cfg_type;

   typedef struct packed {
      event_type   event_res;
      logic [15:0] servo_position;
      logic [3:0]  tries_left;
      logic [1:0]  lock_mode;
      logic [2:0]  digits_entered;
   } result_type;

endpackage

FILE: rtl/kcl_ram.sv
module kcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kcl_ctrl.sv
module kcl_ctrl #(
   parameter int CODE_LENGTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  kcl_pkg::cfg_type    cfg,
   input  logic                accept,
   input  logic [7:0]          key_code,
   output logic                push,
   output kcl_pkg::result_type result
);

   localparam int CW = $clog2(CODE_LENGTH);
   localparam int AW = CW + 1;
   localparam logic [CW-1:0] LAST = CW'(CODE_LENGTH - 1);

   typedef enum logic [1:0] {
      MODE_ENTRY    = 2'd0,
      MODE_MENU     = 2'd1,
      MODE_NEW_CODE = 2'd2
   } mode_state_type;

   mode_state_type mode_ff, mode_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [3:0]     retry_ff, retry_in;
   logic [15:0]    servo_ff, servo_in;
   // bank select: the stored code lives in bank sel_ff, the entry goes to the other one
   logic           sel_ff, sel_in;
   logic           erased_ff, erased_in;
   logic           mis_ff, mis_in;
   logic           e0_ff, e0_in;
   logic           e1_ff, e1_in;

   logic           key_valid;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     stored_byte;
   logic           mis_new;
   logic           e0_new;
   logic           e1_new;
   logic           entry_full;
   kcl_pkg::event_type ev;
   logic [31:0]    cnt_wide;

   kcl_ram #(
      .WIDTH(8),
      .DEPTH(2 ** AW)
   ) u_code_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(key_code),
      .rd_addr(rd_addr),
      .rd_data(stored_byte)
   );

   assign key_valid = accept && (key_code != kcl_pkg::KEY_NONE);
   assign wr_addr = {~sel_ff, cnt_ff};
   // look ahead so the stored byte for the next position is ready when its key arrives
   assign rd_addr = {sel_in, cnt_in};

   // running compare against the stored code, one byte per key
   assign mis_new = ((cnt_ff == '0) ? 1'b0 : mis_ff) | (key_code != stored_byte);
   assign e0_new = (cnt_ff == CW'(0)) ? (key_code == kcl_pkg::ERASED_BYTE) : e0_ff;
   assign e1_new = (cnt_ff == CW'(1)) ? (key_code == kcl_pkg::ERASED_BYTE) : e1_ff;
   assign entry_full = (cnt_ff == LAST);

   always_comb begin
      mode_in = mode_ff;
      cnt_in = cnt_ff;
      retry_in = retry_ff;
      servo_in = servo_ff;
      sel_in = sel_ff;
      erased_in = erased_ff;
      mis_in = mis_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      wr_en = 1'b0;
      ev = kcl_pkg::EV_DIGIT;
      if (key_valid) begin
         unique case (mode_ff)
            MODE_MENU: begin
               if (key_code == kcl_pkg::KEY_ONE) begin
                  mode_in = MODE_NEW_CODE;
                  cnt_in = '0;
               end else if (key_code == kcl_pkg::KEY_TWO) begin
                  servo_in = cfg.lock_position;
                  mode_in = MODE_ENTRY;
                  cnt_in = '0;
                  ev = kcl_pkg::EV_LOCKING;
               end
            end
            MODE_NEW_CODE: begin
               if (key_code == cfg.clear_key) begin
                  cnt_in = '0;
                  ev = kcl_pkg::EV_CLEARED;
               end else begin
                  wr_en = 1'b1;
                  mis_in = mis_new;
                  e0_in = e0_new;
                  e1_in = e1_new;
                  if (entry_full) begin
                     cnt_in = '0;
                     sel_in = ~sel_ff;
                     erased_in = e0_new && e1_new;
                     mode_in = MODE_MENU;
                     ev = kcl_pkg::EV_CHANGED;
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
            end
            default: begin
               mode_in = MODE_ENTRY;
               if (key_code == cfg.clear_key) begin
                  cnt_in = '0;
                  ev = kcl_pkg::EV_CLEARED;
               end else begin
                  wr_en = 1'b1;
                  mis_in = mis_new;
                  e0_in = e0_new;
                  e1_in = e1_new;
                  if (entry_full) begin
                     cnt_in = '0;
                     if (erased_ff) begin
                        sel_in = ~sel_ff;
                        erased_in = e0_new && e1_new;
                        ev = kcl_pkg::EV_SAVED;
                     end else if (!mis_new) begin
                        retry_in = cfg.retry_reload;
                        servo_in = cfg.open_position;
                        mode_in = MODE_MENU;
                        ev = kcl_pkg::EV_OPENING;
                     end else if (retry_ff == 4'd0) begin
                        retry_in = cfg.retry_reload;
                        ev = kcl_pkg::EV_BLOCKED;
                     end else begin
                        retry_in = retry_ff - 4'd1;
                        ev = kcl_pkg::EV_WRONG;
                     end
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENTRY;
         cnt_ff <= '0;
         retry_ff <= kcl_pkg::RETRY_RELOAD_RESET;
         servo_ff <= '0;
         sel_ff <= 1'b0;
         erased_ff <= 1'b1;
         mis_ff <= 1'b0;
         e0_ff <= 1'b0;
         e1_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff <= cnt_in;
         retry_ff <= retry_in;
         servo_ff <= servo_in;
         sel_ff <= sel_in;
         erased_ff <= erased_in;
         mis_ff <= mis_in;
         e0_ff <= e0_in;
         e1_ff <= e1_in;
      end
   end

   assign cnt_wide = 32'(cnt_in);
   assign push = key_valid;

   always_comb begin
      result.event_res = ev;
      result.servo_position = servo_in;
      result.tries_left = retry_in;
      result.lock_mode = mode_in;
      result.digits_entered = cnt_wide[2:0];
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !key_valid |=> $stable(cnt_ff) && $stable(sel_ff) && $stable(mode_ff))
      else $error("entry state moved without a key");

   a_change_flips_bank: assert property (@(posedge clock) disable iff (reset)
      (push && (result.event_res == kcl_pkg::EV_CHANGED || result.event_res == kcl_pkg::EV_SAVED))
      |=> (sel_ff != $past(sel_ff)) && (cnt_ff == '0))
      else $error("new code did not switch banks");

   a_open_enters_menu: assert property (@(posedge clock) disable iff (reset)
      (push && result.event_res == kcl_pkg::EV_OPENING)
      |=> (mode_ff == MODE_MENU) && (servo_ff == $past(cfg.open_position)))
      else $error("opening did not reach the menu");

endmodule

FILE: rtl/kcl_rsp_buf.sv
module kcl_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kcl_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kcl_pkg::result_type rsp_data
);

   logic                out_v_ff, out_v_in;
   logic                skid_v_ff, skid_v_in;
   kcl_pkg::result_type out_ff, out_in;
   kcl_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop = out_v_ff && !rsp_stall;

   always_comb begin
      out_v_in = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in = out_ff;
      skid_in = skid_ff;
      if (pop) begin
         if (skid_v_ff) begin
            out_in = skid_ff;
            skid_v_in = 1'b0;
         end else if (push) begin
            out_in = push_data;
         end else begin
            out_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff) begin
            out_in = push_data;
            out_v_in = 1'b1;
         end else begin
            skid_in = push_data;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign full = skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without an output entry");

endmodule

FILE: rtl/keypad_code_lock.sv
// keypad code lock
// req channel: one key press per transaction on req_key_code. a key code of
// zero is taken but changes nothing and gives no response.
// rsp channel: one response per nonzero key, carrying the event, the servo
// compare value, tries left, the lock mode and the digits held in the entry.
// each response is registered in the response buffer. throughput is one key
// per cycle while req_stall is low; the code ram is read one position ahead of
// the entry count, so each key compares against its stored byte with no stall.
// the code ram holds two banks of CODE_LENGTH bytes: the stored code and the
// entry being typed. saving a code swaps the banks instead of copying.
// csr port: csr_wr_en writes csr_wdata to the register at csr_index at once;
// write only while no transaction is in flight.
// reset (synchronous) restores register defaults, marks the code as erased
// and empties the response buffer; no clearing pass is needed.
// when rsp_stall is high, one more response is held in a skid entry;
// req_stall rises only while that skid entry is occupied.
module keypad_code_lock #(
   parameter int CODE_LENGTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_key_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_servo_position,
   output logic [3:0]  rsp_tries_left,
   output logic [1:0]  rsp_lock_mode,
   output logic [2:0]  rsp_digits_entered,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   kcl_pkg::cfg_type    cfg_ff;
   kcl_pkg::result_type result;
   kcl_pkg::result_type rsp_data;
   logic                push;
   logic                accept;
   logic                full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_position <= kcl_pkg::OPEN_POSITION_RESET;
         cfg_ff.lock_position <= kcl_pkg::LOCK_POSITION_RESET;
         cfg_ff.retry_reload <= kcl_pkg::RETRY_RELOAD_RESET;
         cfg_ff.clear_key <= kcl_pkg::CLEAR_KEY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            kcl_pkg::CSR_OPEN_POSITION: cfg_ff.open_position <= csr_wdata;
            kcl_pkg::CSR_LOCK_POSITION: cfg_ff.lock_position <= csr_wdata;
            kcl_pkg::CSR_RETRY_RELOAD:  cfg_ff.retry_reload <= csr_wdata[3:0];
            kcl_pkg::CSR_CLEAR_KEY:     cfg_ff.clear_key <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !full;
   assign req_stall = full;

   kcl_ctrl #(
      .CODE_LENGTH(CODE_LENGTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .key_code(req_key_code),
      .push    (push),
      .result  (result)
   );

   kcl_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(result),
      .full     (full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   assign rsp_event_res = rsp_data.event_res;
   assign rsp_servo_position = rsp_data.servo_position;
   assign rsp_tries_left = rsp_data.tries_left;
   assign rsp_lock_mode = rsp_data.lock_mode;
   assign rsp_digits_entered = rsp_data.digits_entered;

endmodule

FILE: tb/sv/keypad_code_lock_tb.sv
`timescale 1ns / 100ps

module keypad_code_lock_tb;

   localparam int CODE_LEN = 8;
   localparam int STALL_LIMIT = 2000;
   localparam logic [1:0] MODE_ENTRY = 2'd0;
   localparam logic [1:0] MODE_MENU = 2'd1;
   localparam logic [1:0] MODE_NEW_CODE = 2'd2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_key_code = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [15:0] rsp_servo_position;
   logic [3:0]  rsp_tries_left;
   logic [1:0]  rsp_lock_mode;
   logic [2:0]  rsp_digits_entered;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   // lock state as the predictor sees it
   kcl_pkg::cfg_type lk_cfg;
   logic [63:0] lk_code;
   logic [63:0] lk_entry;
   int          lk_count;
   logic [3:0]  lk_tries;
   logic [1:0]  lk_mode;
   logic [15:0] lk_servo;

   kcl_pkg::result_type awaited_responses[$];
   int          errors = 0;
   int          keys_sent = 0;
   int          quiet_cycles = 0;
   int          rsp_hold_cycles = 0;
   bit          send_gaps = 1'b1;
   bit          rsp_gaps = 1'b1;

   keypad_code_lock dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_servo_position (rsp_servo_position),
      .rsp_tries_left     (rsp_tries_left),
      .rsp_lock_mode      (rsp_lock_mode),
      .rsp_digits_entered (rsp_digits_entered),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // works out the lock's reaction to one accepted key
   function automatic void apply_key(logic [7:0] key);
      kcl_pkg::result_type r;
      if (key == kcl_pkg::KEY_NONE) return;
      r.event_res = kcl_pkg::EV_DIGIT;
      if (lk_mode == MODE_MENU) begin
         if (key == kcl_pkg::KEY_ONE) begin
            lk_mode = MODE_NEW_CODE;
            lk_count = 0;
         end else if (key == kcl_pkg::KEY_TWO) begin
            lk_servo = lk_cfg.lock_position;
            lk_mode = MODE_ENTRY;
            lk_count = 0;
            r.event_res = kcl_pkg::EV_LOCKING;
         end
      end else if (key == lk_cfg.clear_key) begin
         lk_count = 0;
         r.event_res = kcl_pkg::EV_CLEARED;
      end else begin
         lk_entry[8*lk_count +: 8] = key;
         lk_count++;
         if (lk_count == CODE_LEN) begin
            lk_count = 0;
            if (lk_mode == MODE_NEW_CODE) begin
               lk_code = lk_entry;
               lk_mode = MODE_MENU;
               r.event_res = kcl_pkg::EV_CHANGED;
            end else if (lk_code[15:0] == {kcl_pkg::ERASED_BYTE, kcl_pkg::ERASED_BYTE}) begin
               lk_code = lk_entry;
               r.event_res = kcl_pkg::EV_SAVED;
            end else if (lk_code == lk_entry) begin
               lk_tries = lk_cfg.retry_reload;
               lk_servo = lk_cfg.open_position;
               lk_mode = MODE_MENU;
               r.event_res = kcl_pkg::EV_OPENING;
            end else if (lk_tries == 4'd0) begin
               lk_tries = lk_cfg.retry_reload;
               r.event_res = kcl_pkg::EV_BLOCKED;
            end else begin
               lk_tries = lk_tries - 4'd1;
               r.event_res = kcl_pkg::EV_WRONG;
            end
         end
      end
      r.servo_position = lk_servo;
      r.tries_left = lk_tries;
      r.lock_mode = lk_mode;
      r.digits_entered = 3'(lk_count);
      awaited_responses.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      kcl_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t unexpected transaction: expected none actual event %0d",
                     $time, rsp_event_res);
            errors++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("event_res", 16'(want.event_res), 16'(rsp_event_res));
            check_field("servo_position", want.servo_position, rsp_servo_position);
            check_field("tries_left", 16'(want.tries_left), 16'(rsp_tries_left));
            check_field("lock_mode", 16'(want.lock_mode), 16'(rsp_lock_mode));
            check_field("digits_entered", 16'(want.digits_entered),
                        16'(rsp_digits_entered));
         end
      end
   end

   // receiver: random stall bursts, or one long hold when asked
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic press_key(logic [7:0] key);
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key_code <= key;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (key != kcl_pkg::KEY_NONE) keys_sent++;
      apply_key(key);
   endtask

   task automatic type_code(logic [63:0] code);
      for (int i = 0; i < CODE_LEN; i++) press_key(code[8*i +: 8]);
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      // a zero key may still be in flight with nothing expected
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         kcl_pkg::CSR_OPEN_POSITION: lk_cfg.open_position = data;
         kcl_pkg::CSR_LOCK_POSITION: lk_cfg.lock_position = data;
         kcl_pkg::CSR_RETRY_RELOAD:  lk_cfg.retry_reload = data[3:0];
         kcl_pkg::CSR_CLEAR_KEY:     lk_cfg.clear_key = data[7:0];
      endcase
   endtask

   function automatic logic [7:0] rand_key();
      logic [7:0] k;
      do k = 8'($urandom_range(1, 255)); while (k == lk_cfg.clear_key);
      return k;
   endfunction

   function automatic logic [63:0] random_code();
      logic [63:0] code;
      for (int i = 0; i < CODE_LEN; i++) code[8*i +: 8] = rand_key();
      // a code that starts with two erased bytes reads back as no code
      if ($urandom_range(0, 7) == 0) code[15:0] = {kcl_pkg::ERASED_BYTE, kcl_pkg::ERASED_BYTE};
      return code;
   endfunction

   // one short user session, mostly well formed, picked from the lock's mode
   task automatic random_action();
      logic [63:0] code;
      int pick;
      int pos;
      pick = $urandom_range(0, 9);
      if (lk_mode == MODE_MENU) begin
         if (pick < 4) press_key(kcl_pkg::KEY_ONE);
         else if (pick < 7) press_key(kcl_pkg::KEY_TWO);
         else if (pick < 9) press_key(rand_key());
         else press_key(lk_cfg.clear_key);
      end else begin
         if (lk_count != 0) press_key(lk_cfg.clear_key);
         code = lk_code;
         if (lk_mode == MODE_NEW_CODE || pick == 6) code = random_code();
         if (pick == 5) begin
            pos = $urandom_range(0, CODE_LEN - 1);
            do code[8*pos +: 8] = rand_key(); while (code[8*pos +: 8] == lk_code[8*pos +: 8]);
         end
         if (pick == 7) repeat ($urandom_range(1, CODE_LEN - 1)) press_key(rand_key());
         else if (pick == 8) press_key(kcl_pkg::KEY_NONE);
         else type_code(code);
      end
   endtask

   task automatic run_random(int n);
      int stop;
      stop = keys_sent + n;
      while (keys_sent < stop) random_action();
   endtask

   // digits, a clear and no key, then the first entry is saved, then wrong and right entries
   task automatic test_first_code();
      press_key(kcl_pkg::KEY_ONE);
      press_key(kcl_pkg::KEY_TWO);
      press_key(lk_cfg.clear_key);
      press_key(kcl_pkg::KEY_NONE);
      type_code(64'h3435_3637_3839_FF01);
      type_code(64'h4141_4141_4141_4141);
      type_code(64'h3435_3637_3839_FF01);
   endtask

   // menu: ignored keys, new code that reads as erased, lock, fresh save
   task automatic test_menu();
      press_key(lk_cfg.clear_key);
      press_key(8'hFF);
      press_key(kcl_pkg::KEY_ONE);
      press_key(8'h35);
      press_key(lk_cfg.clear_key);
      type_code(64'h3132_3334_3536_FFFF);
      press_key(kcl_pkg::KEY_TWO);
      type_code(64'h3938_3736_3534_3332);
   endtask

   task automatic test_backpressure();
      bit keep_gaps;
      wait_for_quiet();
      keep_gaps = send_gaps;
      send_gaps = 1'b0;
      rsp_hold_cycles = 60;
      repeat (16) press_key(rand_key());
      send_gaps = keep_gaps;
      wait_for_quiet();
   endtask

   task automatic test_register_sweep();
      kcl_pkg::cfg_type settings [5];
      settings[0] = {16'hFFFF, 16'h0000, 4'd0, 8'd1};
      settings[1] = {16'h0000, 16'hFFFF, 4'd15, 8'hFF};
      settings[2] = {16'h1234, 16'h4321, 4'd1, kcl_pkg::KEY_ONE};
      settings[3] = {16'h8001, 16'h7FFE, 4'd3, kcl_pkg::KEY_TWO};
      settings[4] = {kcl_pkg::OPEN_POSITION_RESET, kcl_pkg::LOCK_POSITION_RESET,
                     kcl_pkg::RETRY_RELOAD_RESET, kcl_pkg::CLEAR_KEY_RESET};
      foreach (settings[i]) begin
         wait_for_quiet();
         write_reg(kcl_pkg::CSR_OPEN_POSITION, settings[i].open_position);
         write_reg(kcl_pkg::CSR_LOCK_POSITION, settings[i].lock_position);
         // upper bits are junk and must be dropped
         write_reg(kcl_pkg::CSR_RETRY_RELOAD, {12'($urandom), settings[i].retry_reload});
         write_reg(kcl_pkg::CSR_CLEAR_KEY, {8'($urandom), settings[i].clear_key});
         run_random(60);
      end
   endtask

   task automatic test_random_traffic();
      run_random(120);
      send_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_random(80);
   endtask

   initial begin
      lk_cfg = {kcl_pkg::OPEN_POSITION_RESET, kcl_pkg::LOCK_POSITION_RESET,
                kcl_pkg::RETRY_RELOAD_RESET, kcl_pkg::CLEAR_KEY_RESET};
      lk_code = '1;
      lk_entry = '0;
      lk_count = 0;
      lk_tries = kcl_pkg::RETRY_RELOAD_RESET;
      lk_mode = MODE_ENTRY;
      lk_servo = 16'd0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_first_code();
      test_menu();
      test_backpressure();
      test_register_sweep();
      test_random_traffic();

      wait_for_quiet();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
